// File: src/thbc_pkg.sv
// ----------------------------------------------------------------------------
// thbc_pkg
// Shared constants, codes and types of the terrain height query block.
// ----------------------------------------------------------------------------
package thbc_pkg;

  // Default heightmap limits; the top level takes them as parameter defaults.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Field widths fixed by the interface.
  localparam int GRID_W    = 9;
  localparam int COORD_W   = 24;
  localparam int SCALE_W   = 24;
  localparam int HGT_W     = 8;
  localparam int LEVEL_W   = 16;
  localparam int WT_W      = 17;
  localparam int ACC_W     = 24;
  localparam int PROD_W    = 48;
  localparam int CFG_IDX_W = 3;

  // Four height taps per query, one memory read each.
  localparam int TAPS     = 4;
  // Cycles from the accept edge to the edge that loads the result registers.
  localparam int PIPE_LEN = 8;

  // Register reset values.
  localparam logic [GRID_W-1:0]  GRID_RST  = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;

  // Lift above the terrain in Q8.8: 5.0 normally, 8.0 when forced.
  localparam logic [COORD_W-1:0] LIFT_SOFT  = 24'd1280;
  localparam logic [COORD_W-1:0] LIFT_FORCE = 24'd2048;

  // Weight of a tap that takes the whole sum (fractions both zero).
  localparam logic [WT_W-1:0] WT_FULL = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_W   = 3'd0,
    CFG_GRID_H   = 3'd1,
    CFG_SCALE_X  = 3'd2,
    CFG_SCALE_Z  = 3'd3,
    CFG_CENTRE_X = 3'd4,
    CFG_CENTRE_Z = 3'd5
  } cfg_reg_t;

  // Item operations.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Bilinear weights of the four taps, Q1.16 products of Q1.8 fraction terms.
  typedef struct packed {
    logic [WT_W-1:0] w00;
    logic [WT_W-1:0] w10;
    logic [WT_W-1:0] w01;
    logic [WT_W-1:0] w11;
  } tap_wt_t;

  // Per-query values carried to the result stage.
  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_z;
    logic signed [COORD_W-1:0] point_y;
    logic                      force_req;
    logic                      off_map;
  } qry_meta_t;

endpackage

// File: src/thbc_hmem.sv
// ----------------------------------------------------------------------------
// thbc_hmem
// Heightmap store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module thbc_hmem #(
  parameter int DEPTH  = thbc_pkg::MAX_WIDTH_DEF * thbc_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [thbc_pkg::HGT_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [thbc_pkg::HGT_W-1:0]  rd_data
);
  import thbc_pkg::*;

  logic [HGT_W-1:0] mem [DEPTH];
  logic [HGT_W-1:0] rd_data_r;

  // A read and a write of the same entry in one cycle return the old byte.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/thbc_coord.sv
// ----------------------------------------------------------------------------
// thbc_coord
// Scales a query point to cell coordinates, detects off-map points and
// produces the clamped tap columns and rows with their bilinear weights.
// ----------------------------------------------------------------------------
module thbc_coord #(
  parameter int MAX_WIDTH  = thbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = thbc_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int ROW_W     = $clog2(MAX_HEIGHT)
) (
  input  logic                                clk,
  input  logic                                ld_prod,
  input  logic                                ld_tap,
  input  logic signed [thbc_pkg::COORD_W-1:0] point_x,
  input  logic signed [thbc_pkg::COORD_W-1:0] point_y,
  input  logic signed [thbc_pkg::COORD_W-1:0] point_z,
  input  logic                                force_req,
  input  logic [thbc_pkg::GRID_W-1:0]         grid_width,
  input  logic [thbc_pkg::GRID_W-1:0]         grid_height,
  input  logic [thbc_pkg::SCALE_W-1:0]        scale_x,
  input  logic [thbc_pkg::SCALE_W-1:0]        scale_z,
  input  logic signed [thbc_pkg::COORD_W-1:0] centre_x,
  input  logic signed [thbc_pkg::COORD_W-1:0] centre_z,
  output logic [COL_W-1:0]                    col0,
  output logic [COL_W-1:0]                    col1,
  output logic [ROW_W-1:0]                    row0,
  output logic [ROW_W-1:0]                    row1,
  output thbc_pkg::tap_wt_t                   wt,
  output thbc_pkg::qry_meta_t                 meta
);
  import thbc_pkg::*;

  localparam int WW = ($clog2(MAX_WIDTH + 1) > GRID_W) ? $clog2(MAX_WIDTH + 1) : GRID_W;
  localparam int WH = ($clog2(MAX_HEIGHT + 1) > GRID_W) ? $clog2(MAX_HEIGHT + 1) : GRID_W;

  // A scaled coordinate at or below -1.0 lies off the map.
  localparam logic signed [PROD_W-1:0] NEG_LIM = -48'sd16777216;

  // Product stage.
  logic signed [PROD_W:0]    prod_x_full;
  logic signed [PROD_W:0]    prod_z_full;
  logic signed [PROD_W-1:0]  prod_x_r;
  logic signed [PROD_W-1:0]  prod_z_r;
  logic signed [COORD_W-1:0] px_r;
  logic signed [COORD_W-1:0] py_r;
  logic signed [COORD_W-1:0] pz_r;
  logic                      force_r;

  // Decode stage.
  logic [WW-1:0]      eff_w;
  logic [WH-1:0]      eff_h;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_z;
  logic [HGT_W-1:0]   frac_x;
  logic [HGT_W-1:0]   frac_z;
  logic               off_map;
  logic [COL_W-1:0]   c0;
  logic [COL_W-1:0]   c1;
  logic [ROW_W-1:0]   r0;
  logic [ROW_W-1:0]   r1;
  logic [WW-1:0]      c_next;
  logic [WH-1:0]      r_next;
  logic [8:0]         ax;
  logic [8:0]         az;
  logic [17:0]        m00;
  logic [17:0]        m10;
  logic [17:0]        m01;
  logic [17:0]        m11;
  tap_wt_t            wt_nxt;
  qry_meta_t          meta_nxt;

  logic [COL_W-1:0]   col0_r;
  logic [COL_W-1:0]   col1_r;
  logic [ROW_W-1:0]   row0_r;
  logic [ROW_W-1:0]   row1_r;
  tap_wt_t            wt_r;
  qry_meta_t          meta_r;

  // Exact products with 24 fraction bits; the scales are unsigned.
  assign prod_x_full = point_x * $signed({1'b0, scale_x});
  assign prod_z_full = point_z * $signed({1'b0, scale_z});

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      prod_x_r <= prod_x_full[PROD_W-1:0];
      prod_z_r <= prod_z_full[PROD_W-1:0];
      px_r     <= point_x;
      py_r     <= point_y;
      pz_r     <= point_z;
      force_r  <= force_req;
    end
  end

  // Grid size in use, saturated to the supported range.
  always_comb begin
    if (grid_width < 9'd2) begin
      eff_w = WW'(2);
    end else if (WW'(grid_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    if (grid_height < 9'd2) begin
      eff_h = WH'(2);
    end else if (WH'(grid_height) > WH'(MAX_HEIGHT)) begin
      eff_h = WH'(MAX_HEIGHT);
    end else begin
      eff_h = WH'(grid_height);
    end
  end

  // Floor cell and top fraction byte of each scaled coordinate.
  assign cell_x = prod_x_r[PROD_W-1:24];
  assign cell_z = prod_z_r[PROD_W-1:24];
  assign frac_x = prod_x_r[23:16];
  assign frac_z = prod_z_r[23:16];

  assign off_map = (prod_x_r <= NEG_LIM) || (prod_z_r <= NEG_LIM) ||
                   (!cell_x[COORD_W-1] && (cell_x >= COORD_W'(eff_w))) ||
                   (!cell_z[COORD_W-1] && (cell_z >= COORD_W'(eff_h)));

  // Tap columns and rows, clamped to the grid; an off-map point uses the centre cell.
  always_comb begin
    if (off_map) begin
      c0 = COL_W'(eff_w >> 1);
    end else if (cell_x[COORD_W-1]) begin
      c0 = '0;
    end else begin
      c0 = COL_W'(cell_x);
    end
    c_next = WW'(c0) + WW'(1);
    if (!off_map && cell_x[COORD_W-1]) begin
      c1 = '0;
    end else if (c_next >= eff_w) begin
      c1 = COL_W'(eff_w - WW'(1));
    end else begin
      c1 = COL_W'(c_next);
    end

    if (off_map) begin
      r0 = ROW_W'(eff_h >> 1);
    end else if (cell_z[COORD_W-1]) begin
      r0 = '0;
    end else begin
      r0 = ROW_W'(cell_z);
    end
    r_next = WH'(r0) + WH'(1);
    if (!off_map && cell_z[COORD_W-1]) begin
      r1 = '0;
    end else if (r_next >= eff_h) begin
      r1 = ROW_W'(eff_h - WH'(1));
    end else begin
      r1 = ROW_W'(r_next);
    end
  end

  // Bilinear weights from the fraction bytes.
  assign ax  = 9'd256 - {1'b0, frac_x};
  assign az  = 9'd256 - {1'b0, frac_z};
  assign m00 = ax * az;
  assign m10 = {1'b0, frac_x} * az;
  assign m01 = ax * {1'b0, frac_z};
  assign m11 = {1'b0, frac_x} * {1'b0, frac_z};

  always_comb begin
    if (off_map) begin
      wt_nxt.w00 = WT_FULL;
      wt_nxt.w10 = '0;
      wt_nxt.w01 = '0;
      wt_nxt.w11 = '0;
    end else begin
      wt_nxt.w00 = m00[WT_W-1:0];
      wt_nxt.w10 = m10[WT_W-1:0];
      wt_nxt.w01 = m01[WT_W-1:0];
      wt_nxt.w11 = m11[WT_W-1:0];
    end
    meta_nxt.new_x     = off_map ? centre_x : px_r;
    meta_nxt.new_z     = off_map ? centre_z : pz_r;
    meta_nxt.point_y   = py_r;
    meta_nxt.force_req = force_r;
    meta_nxt.off_map   = off_map;
  end

  // Held for the four tap reads that follow.
  always_ff @(posedge clk) begin
    if (ld_tap) begin
      col0_r <= c0;
      col1_r <= c1;
      row0_r <= r0;
      row1_r <= r1;
      wt_r   <= wt_nxt;
      meta_r <= meta_nxt;
    end
  end

  assign col0 = col0_r;
  assign col1 = col1_r;
  assign row0 = row0_r;
  assign row1 = row1_r;
  assign wt   = wt_r;
  assign meta = meta_r;

endmodule

// File: src/terrain_height_bilinear_clamp.sv
// ----------------------------------------------------------------------------
// terrain_height_bilinear_clamp
// Heightmap store with bilinear height queries that lift points above the
// terrain and move off-map points to the configured centre.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                   Transfer
//  -------  --------------------------------------  ----------------------------
//  input    start, busy, in_*                       start high while busy low
//  result   out_valid, out_*                        every cycle out_valid is high
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready high
//
// Every item gives its result, in order.
// A query holds busy high after its transfer, counted down in gap_r, since
// its four height taps share the single read port of the heightmap.
// Height writes are taken in every cycle in which busy is low.
// Reset clears control and configuration; the heightmap is not cleared and an
// entry reads as unknown until written. The receiver cannot stall results.
module terrain_height_bilinear_clamp #(
  parameter int MAX_WIDTH  = thbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = thbc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input items
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_op,
  input  logic [7:0]                            in_cell_x,
  input  logic [7:0]                            in_cell_y,
  input  logic [thbc_pkg::HGT_W-1:0]            in_height_value,
  input  logic signed [thbc_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [thbc_pkg::COORD_W-1:0]   in_point_y,
  input  logic signed [thbc_pkg::COORD_W-1:0]   in_point_z,
  input  logic                                  in_force_req,
  // Results
  output logic                                  out_valid,
  output logic signed [thbc_pkg::COORD_W-1:0]   out_new_x,
  output logic signed [thbc_pkg::COORD_W-1:0]   out_new_y,
  output logic signed [thbc_pkg::COORD_W-1:0]   out_new_z,
  output logic [thbc_pkg::LEVEL_W-1:0]          out_terrain_level,
  output logic                                  out_lifted,
  output logic                                  out_off_map,
  // Configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [thbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [thbc_pkg::SCALE_W-1:0]          cfg_data
);
  import thbc_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [1:0] QRY_GAP = 2'(TAPS - 1);

  // Configuration registers.
  logic [GRID_W-1:0]         grid_w_r;
  logic [GRID_W-1:0]         grid_h_r;
  logic [SCALE_W-1:0]        scale_x_r;
  logic [SCALE_W-1:0]        scale_z_r;
  logic signed [COORD_W-1:0] centre_x_r;
  logic signed [COORD_W-1:0] centre_z_r;

  // Flow control.
  logic                accept;
  logic                accept_q;
  logic [1:0]          gap_r;
  logic [PIPE_LEN-1:0] pv_r;
  logic [PIPE_LEN-1:0] pq_r;

  // Captured item.
  logic [7:0]                s0_cell_x_r;
  logic [7:0]                s0_cell_y_r;
  logic [HGT_W-1:0]          s0_height_r;
  logic signed [COORD_W-1:0] s0_point_x_r;
  logic signed [COORD_W-1:0] s0_point_y_r;
  logic signed [COORD_W-1:0] s0_point_z_r;
  logic                      s0_force_r;

  // Heightmap write path.
  logic                wr_ok;
  logic                wr_en_r;
  logic [ADDR_W-1:0]   wr_addr_r;
  logic [HGT_W-1:0]    wr_data_r;

  // Tap read and accumulation.
  logic [COL_W-1:0]   col0;
  logic [COL_W-1:0]   col1;
  logic [ROW_W-1:0]   row0;
  logic [ROW_W-1:0]   row1;
  tap_wt_t            wt;
  qry_meta_t          meta;
  logic               sel_col1;
  logic               sel_row1;
  logic [COL_W-1:0]   rd_col;
  logic [ROW_W-1:0]   rd_row;
  logic [ADDR_W-1:0]  rd_addr;
  logic [HGT_W-1:0]   rd_data;
  logic [WT_W-1:0]    rd_w_nxt;
  logic [WT_W-1:0]    rd_w_r;
  logic [24:0]        tap_prod;
  logic [ACC_W-1:0]   acc_r;
  qry_meta_t          m_r;

  // Result stage.
  logic [LEVEL_W-1:0]        level;
  logic                      lift;
  logic signed [COORD_W-1:0] lift_y;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_new_x_r;
  logic signed [COORD_W-1:0] out_new_y_r;
  logic signed [COORD_W-1:0] out_new_z_r;
  logic [LEVEL_W-1:0]        out_level_r;
  logic                      out_lifted_r;
  logic                      out_off_map_r;

  // Configuration register writes; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r   <= GRID_RST;
      grid_h_r   <= GRID_RST;
      scale_x_r  <= SCALE_RST;
      scale_z_r  <= SCALE_RST;
      centre_x_r <= '0;
      centre_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GRID_W:   grid_w_r   <= cfg_data[GRID_W-1:0];
        CFG_GRID_H:   grid_h_r   <= cfg_data[GRID_W-1:0];
        CFG_SCALE_X:  scale_x_r  <= cfg_data;
        CFG_SCALE_Z:  scale_z_r  <= cfg_data;
        CFG_CENTRE_X: centre_x_r <= cfg_data;
        CFG_CENTRE_Z: centre_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input transfer; a query holds busy high through gap_r to free the read port.
  assign busy     = (gap_r != 2'd0);
  assign accept   = start && !busy;
  assign accept_q = accept && (op_t'(in_op) == OP_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
      pv_r  <= '0;
      pq_r  <= '0;
    end else begin
      if (accept_q) begin
        gap_r <= QRY_GAP;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
      pv_r <= {pv_r[PIPE_LEN-2:0], accept};
      pq_r <= {pq_r[PIPE_LEN-2:0], accept_q};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_cell_x_r  <= in_cell_x;
      s0_cell_y_r  <= in_cell_y;
      s0_height_r  <= in_height_value;
      s0_point_x_r <= in_point_x;
      s0_point_y_r <= in_point_y;
      s0_point_z_r <= in_point_z;
      s0_force_r   <= in_force_req;
    end
  end

  // Height writes land from the wr_*_r registers, behind the last tap
  // read of any earlier query.
  assign wr_ok = (int'(s0_cell_x_r) < MAX_WIDTH) && (int'(s0_cell_y_r) < MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r <= 1'b0;
    end else begin
      wr_en_r <= pv_r[0] && !pq_r[0] && wr_ok;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= ADDR_W'(ROW_W'(s0_cell_y_r)) * ADDR_W'(MAX_WIDTH) +
                 ADDR_W'(COL_W'(s0_cell_x_r));
    wr_data_r <= s0_height_r;
  end

  // Scaling, off-map test and tap coordinates.
  thbc_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk         (clk),
    .ld_prod     (pq_r[0]),
    .ld_tap      (pq_r[1]),
    .point_x     (s0_point_x_r),
    .point_y     (s0_point_y_r),
    .point_z     (s0_point_z_r),
    .force_req   (s0_force_r),
    .grid_width  (grid_w_r),
    .grid_height (grid_h_r),
    .scale_x     (scale_x_r),
    .scale_z     (scale_z_r),
    .centre_x    (centre_x_r),
    .centre_z    (centre_z_r),
    .col0        (col0),
    .col1        (col1),
    .row0        (row0),
    .row1        (row1),
    .wt          (wt),
    .meta        (meta)
  );

  // One tap read per cycle: (c0,r0), (c1,r0), (c0,r1), (c1,r1).
  assign sel_col1 = pq_r[3] || pq_r[5];
  assign sel_row1 = pq_r[4] || pq_r[5];
  assign rd_col   = sel_col1 ? col1 : col0;
  assign rd_row   = sel_row1 ? row1 : row0;
  assign rd_addr  = ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);

  always_comb begin
    if (pq_r[3]) begin
      rd_w_nxt = wt.w10;
    end else if (pq_r[4]) begin
      rd_w_nxt = wt.w01;
    end else if (pq_r[5]) begin
      rd_w_nxt = wt.w11;
    end else begin
      rd_w_nxt = wt.w00;
    end
  end

  thbc_hmem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_hmem (
    .clk     (clk),
    .wr_en   (wr_en_r),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Weighted sum of the taps as their bytes come back.
  assign tap_prod = rd_data * rd_w_r;

  always_ff @(posedge clk) begin
    rd_w_r <= rd_w_nxt;
    if (pq_r[3]) begin
      acc_r <= tap_prod[ACC_W-1:0];
    end else if (pq_r[4] || pq_r[5] || pq_r[6]) begin
      acc_r <= acc_r + tap_prod[ACC_W-1:0];
    end
    if (pq_r[5]) begin
      m_r <= meta;
    end
  end

  // Lift test on the Q8.8 level and result registers.
  assign level  = acc_r[ACC_W-1:8];
  assign lift   = m_r.force_req || (m_r.point_y < $signed({8'd0, level}));
  assign lift_y = $signed({8'd0, level} + (m_r.force_req ? LIFT_FORCE : LIFT_SOFT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_r[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pq_r[PIPE_LEN-1]) begin
      out_new_x_r   <= m_r.new_x;
      out_new_y_r   <= lift ? lift_y : m_r.point_y;
      out_new_z_r   <= m_r.new_z;
      out_level_r   <= level;
      out_lifted_r  <= lift;
      out_off_map_r <= m_r.off_map;
    end else begin
      out_new_x_r   <= '0;
      out_new_y_r   <= '0;
      out_new_z_r   <= '0;
      out_level_r   <= '0;
      out_lifted_r  <= 1'b0;
      out_off_map_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_x         = out_new_x_r;
  assign out_new_y         = out_new_y_r;
  assign out_new_z         = out_new_z_r;
  assign out_terrain_level = out_level_r;
  assign out_lifted        = out_lifted_r;
  assign out_off_map       = out_off_map_r;

endmodule
